[rtl/ctst_pkg.sv]
// Shared types and codes for the cooperative task scheduler table.
// Request and event payload structs, request codes and event codes.
// No dependencies.
`timescale 1ns / 1ps

package ctst_pkg;

    // request codes
    localparam logic [2:0] REQ_ADD      = 3'd0;
    localparam logic [2:0] REQ_TICK     = 3'd1;
    localparam logic [2:0] REQ_DISPATCH = 3'd2;
    localparam logic [2:0] REQ_DELETE   = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    // event codes
    localparam logic [2:0] EVT_ADDED     = 3'd0;
    localparam logic [2:0] EVT_FULL      = 3'd1;
    localparam logic [2:0] EVT_TICK_DONE = 3'd2;
    localparam logic [2:0] EVT_RUN       = 3'd3;
    localparam logic [2:0] EVT_REMOVED   = 3'd4;
    localparam logic [2:0] EVT_NOT_FOUND = 3'd5;
    localparam logic [2:0] EVT_DISP_DONE = 3'd6;
    localparam logic [2:0] EVT_CLEARED   = 3'd7;

    // a dispatch reports at most this many run and removal events
    localparam int WALK_LIMIT = 16;

    localparam int MS_W    = 20;
    localparam int TICKS_W = 16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [19:0] delay_ms;
        logic [19:0] period_ms;
        logic [3:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [3:0]  task_slot;
        logic [31:0] tick_count;
        logic        last;
    } t_evt;

endpackage

[rtl/cooperative_task_scheduler_table_core.sv]
// Add: two passes through the shared reciprocal-multiply divider.
// Tick: one table entry per cycle through the walk.
// Dispatch: two sequencer steps per entry.
// Delete, clear, full table: straight to the final event. Undefined: dropped. Stalls add time.
// One request at a time; ready only while the sequencer is idle.
// Reset (synchronous, active low) empties the table and zeroes the tick counter.
`timescale 1ns / 1ps

module cooperative_task_scheduler_table_core #(
    parameter int MAX_TASKS = 8,
    parameter int TICK_MS   = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  ctst_pkg::t_req  i_req,
    output logic            o_evt_valid,
    input  logic            i_evt_ready,
    output ctst_pkg::t_evt  o_evt
);

    // IW indexes the table, CW holds a count of 0..MAX_TASKS
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_TASKS);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ADD_D    = 3'd1;
    localparam logic [2:0] S_ADD_P    = 3'd2;
    localparam logic [2:0] S_TICK     = 3'd3;
    localparam logic [2:0] S_DISP_RUN = 3'd4;
    localparam logic [2:0] S_DISP_RM  = 3'd5;
    localparam logic [2:0] S_FINAL    = 3'd6;

    // task table
    logic [15:0] r_delay  [MAX_TASKS];
    logic [15:0] r_period [MAX_TASKS];
    logic [7:0]  r_pend   [MAX_TASKS];
    logic        r_mark   [MAX_TASKS];
    logic [15:0] n_delay  [MAX_TASKS];
    logic [15:0] n_period [MAX_TASKS];
    logic [7:0]  n_pend   [MAX_TASKS];
    logic        n_mark   [MAX_TASKS];

    logic [CW-1:0]  r_count, n_count;
    logic [31:0]    r_ticks, n_ticks;
    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_idx, n_idx;
    logic [4:0]     r_nres, n_nres;
    logic [2:0]     r_fin_kind, n_fin_kind;
    logic [3:0]     r_fin_slot, n_fin_slot;
    logic [19:0]    r_period_ms, n_period_ms;
    logic [15:0]    r_new_delay, n_new_delay;
    logic           r_evt_valid, n_evt_valid;
    ctst_pkg::t_evt r_evt, n_evt;

    // shared divider
    logic        div_start;
    logic [19:0] div_dividend;
    logic        div_done;
    logic [15:0] div_quot;

    // one-row shift that packs the table down over a removed slot
    logic          shift_en;
    logic [IW-1:0] shift_from;

    logic          req_acc;
    logic          out_free;
    logic [IW-1:0] widx;
    logic [IW-1:0] cidx;

    ctst_div #(
        .DIVISOR (TICK_MS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // clamp a count or index to the 4-bit slot field
    function automatic logic [3:0] slot_sat(input logic [CW-1:0] v);
        logic [4:0] w;
        w = 5'(v);
        return w[4] ? 4'hF : w[3:0];
    endfunction

    assign o_req_ready = (r_state == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign out_free    = !r_evt_valid || i_evt_ready;
    assign widx        = r_idx[IW-1:0];
    assign cidx        = r_count[IW-1:0];

    always_comb begin
        n_delay     = r_delay;
        n_period    = r_period;
        n_pend      = r_pend;
        n_mark      = r_mark;
        n_count     = r_count;
        n_ticks     = r_ticks;
        n_state     = r_state;
        n_idx       = r_idx;
        n_nres      = r_nres;
        n_fin_kind  = r_fin_kind;
        n_fin_slot  = r_fin_slot;
        n_period_ms = r_period_ms;
        n_new_delay = r_new_delay;
        n_evt_valid = r_evt_valid && !i_evt_ready;
        n_evt       = r_evt;
        div_start    = 1'b0;
        div_dividend = i_req.delay_ms;
        shift_en     = 1'b0;
        shift_from   = widx;

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_idx  = '0;
                    n_nres = '0;
                    case (i_req.req_type)
                        ctst_pkg::REQ_ADD: begin
                            if (r_count < MAX_C) begin
                                // convert delay now, hold period for the second pass
                                div_start   = 1'b1;
                                n_period_ms = i_req.period_ms;
                                n_state     = S_ADD_D;
                            end else begin
                                n_fin_kind = ctst_pkg::EVT_FULL;
                                n_fin_slot = '0;
                                n_state    = S_FINAL;
                            end
                        end
                        ctst_pkg::REQ_TICK: begin
                            n_ticks    = r_ticks + 32'd1;
                            n_fin_kind = ctst_pkg::EVT_TICK_DONE;
                            n_state    = S_TICK;
                        end
                        ctst_pkg::REQ_DISPATCH: begin
                            n_state = S_DISP_RUN;
                        end
                        ctst_pkg::REQ_DELETE: begin
                            n_fin_slot = i_req.slot_index;
                            if (5'(i_req.slot_index) < 5'(r_count)) begin
                                shift_en   = 1'b1;
                                shift_from = IW'(i_req.slot_index);
                                n_count    = r_count - 1'b1;
                                n_fin_kind = ctst_pkg::EVT_REMOVED;
                            end else begin
                                n_fin_kind = ctst_pkg::EVT_NOT_FOUND;
                            end
                            n_state = S_FINAL;
                        end
                        ctst_pkg::REQ_CLEAR: begin
                            // entries past the count are dead; dropping the count clears
                            n_count    = '0;
                            n_fin_kind = ctst_pkg::EVT_CLEARED;
                            n_fin_slot = '0;
                            n_state    = S_FINAL;
                        end
                        default: begin
                            // undefined request: drop silently
                        end
                    endcase
                end
            end

            S_ADD_D: begin
                if (div_done) begin
                    n_new_delay  = div_quot;
                    div_start    = 1'b1;
                    div_dividend = r_period_ms;
                    n_state      = S_ADD_P;
                end
            end

            S_ADD_P: begin
                if (div_done) begin
                    n_delay[cidx]  = r_new_delay;
                    n_period[cidx] = div_quot;
                    n_pend[cidx]   = '0;
                    n_mark[cidx]   = 1'b0;
                    n_count        = r_count + 1'b1;
                    n_fin_kind     = ctst_pkg::EVT_ADDED;
                    n_fin_slot     = slot_sat(r_count);
                    n_state        = S_FINAL;
                end
            end

            S_TICK: begin
                if (r_idx >= r_count) begin
                    n_state = S_FINAL;
                end else begin
                    if (r_delay[widx] != 16'd0) begin
                        n_delay[widx] = r_delay[widx] - 16'd1;
                    end else begin
                        if (r_pend[widx] != 8'hFF) begin
                            n_pend[widx] = r_pend[widx] + 8'd1;
                        end
                        if (r_period[widx] != 16'd0) begin
                            n_delay[widx] = r_period[widx];
                        end else begin
                            n_mark[widx] = 1'b1;
                        end
                    end
                    n_idx = r_idx + 1'b1;
                end
            end

            S_DISP_RUN: begin
                if (out_free) begin
                    if (r_idx >= r_count) begin
                        n_fin_kind = ctst_pkg::EVT_DISP_DONE;
                        n_state    = S_FINAL;
                    end else begin
                        if (r_pend[widx] != 8'd0) begin
                            n_pend[widx] = r_pend[widx] - 8'd1;
                            if (r_nres < 5'(ctst_pkg::WALK_LIMIT)) begin
                                n_evt_valid      = 1'b1;
                                n_evt.event_kind = ctst_pkg::EVT_RUN;
                                n_evt.task_slot  = slot_sat(r_idx);
                                n_evt.tick_count = r_ticks;
                                n_evt.last       = 1'b0;
                                n_nres           = r_nres + 5'd1;
                            end
                        end
                        n_state = S_DISP_RM;
                    end
                end
            end

            S_DISP_RM: begin
                if (out_free) begin
                    if (r_mark[widx]) begin
                        if (r_nres < 5'(ctst_pkg::WALK_LIMIT)) begin
                            n_evt_valid      = 1'b1;
                            n_evt.event_kind = ctst_pkg::EVT_REMOVED;
                            n_evt.task_slot  = slot_sat(r_idx);
                            n_evt.tick_count = r_ticks;
                            n_evt.last       = 1'b0;
                            n_nres           = r_nres + 5'd1;
                        end
                        // pack later entries down; hold the index on the new occupant
                        shift_en = 1'b1;
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                    n_state = S_DISP_RUN;
                end
            end

            S_FINAL: begin
                if (out_free) begin
                    n_evt_valid      = 1'b1;
                    n_evt.event_kind = r_fin_kind;
                    n_evt.task_slot  = ((r_fin_kind == ctst_pkg::EVT_TICK_DONE) ||
                                        (r_fin_kind == ctst_pkg::EVT_DISP_DONE))
                                       ? slot_sat(r_count) : r_fin_slot;
                    n_evt.tick_count = r_ticks;
                    n_evt.last       = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // each entry takes its upper neighbor at or above the removed slot
        if (shift_en) begin
            for (int j = 0; j < MAX_TASKS - 1; j++) begin
                if (IW'(j) >= shift_from) begin
                    n_delay[j]  = r_delay[j+1];
                    n_period[j] = r_period[j+1];
                    n_pend[j]   = r_pend[j+1];
                    n_mark[j]   = r_mark[j+1];
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ticks     <= '0;
            r_evt_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ticks     <= n_ticks;
            r_evt_valid <= n_evt_valid;
        end
    end

    // table and payload
    always_ff @(posedge i_clk) begin
        r_delay     <= n_delay;
        r_period    <= n_period;
        r_pend      <= n_pend;
        r_mark      <= n_mark;
        r_idx       <= n_idx;
        r_nres      <= n_nres;
        r_fin_kind  <= n_fin_kind;
        r_fin_slot  <= n_fin_slot;
        r_period_ms <= n_period_ms;
        r_new_delay <= n_new_delay;
        r_evt       <= n_evt;
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

endmodule

[rtl/ctst_div.sv]
// Divider by a constant: milliseconds to ticks through a reciprocal multiply.
// Result registered, saturated to 16 bits.
// Depends on ctst_pkg for field widths.
`timescale 1ns / 1ps

module ctst_div #(
    parameter int DIVISOR = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ctst_pkg::MS_W-1:0]      i_dividend,
    output logic                           o_done,
    output logic [ctst_pkg::TICKS_W-1:0]   o_quot
);

    // exact for every dividend below 2**MS_W with SH = MS_W + ceil(log2 DIVISOR)
    localparam int LW = $clog2(DIVISOR);
    localparam int SH = ctst_pkg::MS_W + LW;
    localparam int MW = ctst_pkg::MS_W + 2;
    localparam int PW = SH + ctst_pkg::MS_W + 2;
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [PW-1:0]                 prod;
    logic [ctst_pkg::MS_W-1:0]     quot;
    logic                          r_done;
    logic [ctst_pkg::TICKS_W-1:0]  r_quot;

    assign prod = PW'(i_dividend) * PW'(RECIP);
    assign quot = prod[SH +: ctst_pkg::MS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // saturate the quotient to the tick field
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= (|quot[ctst_pkg::MS_W-1:ctst_pkg::TICKS_W]) ? '1
                                                                  : quot[ctst_pkg::TICKS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[rtl/ctst_checker.sv]
// Port-level checks for the scheduler table core, attached by bind.
// Depends on ctst_pkg and cooperative_task_scheduler_table_core.
`timescale 1ns / 1ps

module ctst_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           o_req_ready,
    input ctst_pkg::t_req i_req,
    input logic           o_evt_valid,
    input logic           i_evt_ready,
    input ctst_pkg::t_evt o_evt
);

    // reset leaves the block ready with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_req_ready && !o_evt_valid))
        else $error("not idle after reset");

    // a defined request holds off the next one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && (i_req.req_type == ctst_pkg::REQ_ADD ||
         i_req.req_type == ctst_pkg::REQ_TICK || i_req.req_type == ctst_pkg::REQ_DISPATCH ||
         i_req.req_type == ctst_pkg::REQ_DELETE || i_req.req_type == ctst_pkg::REQ_CLEAR))
        |=> !o_req_ready)
        else $error("ready right after a defined request");

    // a run event is never the final transaction of a request
    a_run_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && o_evt.event_kind == ctst_pkg::EVT_RUN) |-> !o_evt.last)
        else $error("run event marked last");

    // every event other than a run or removal event closes its request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && o_evt.event_kind != ctst_pkg::EVT_RUN &&
         o_evt.event_kind != ctst_pkg::EVT_REMOVED) |-> o_evt.last)
        else $error("closing event not marked last");

    // a stalled event holds
    a_evt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt_valid && !i_evt_ready) |=> (o_evt_valid && $stable(o_evt)))
        else $error("stalled event changed");

endmodule

bind cooperative_task_scheduler_table_core ctst_checker u_ctst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .i_req       (i_req),
    .o_evt_valid (o_evt_valid),
    .i_evt_ready (i_evt_ready),
    .o_evt       (o_evt)
);

[verif/testbench.sv]
// Self-checking testbench for cooperative_task_scheduler_table_core.
// Holds a shadow task table that predicts every event; depends on ctst_pkg and the core.
// Runs a directed table of requests first, then a random mix under random stalls.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_TASKS    = 8;
    localparam int TICK_MS_P    = 10;
    localparam int RAND_ITEMS   = 105;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_req_valid = 1'b0;
    logic           i_evt_ready = 1'b0;
    ctst_pkg::t_req i_req       = '0;
    logic           o_req_ready;
    logic           o_evt_valid;
    ctst_pkg::t_evt o_evt;

    cooperative_task_scheduler_table_core #(
        .MAX_TASKS(NUM_TASKS),
        .TICK_MS  (TICK_MS_P)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_evt_valid(o_evt_valid),
        .i_evt_ready(i_evt_ready),
        .o_evt      (o_evt)
    );

    // One row of the directed sequence; fixed rows carry a hand-written event.
    typedef struct {
        ctst_pkg::t_req req;
        int             reps;
        bit             fixed;
        logic [2:0]     kind;
        logic [3:0]     slot;
    } t_sched_row;

    // Shadow copy of the task table.
    logic [15:0] sh_delay  [NUM_TASKS];
    logic [15:0] sh_period [NUM_TASKS];
    logic [7:0]  sh_pend   [NUM_TASKS];
    logic        sh_mark   [NUM_TASKS];
    int unsigned sh_count;
    logic [31:0] sh_ticks;

    ctst_pkg::t_evt evt_expect_q[$];
    t_sched_row     dir_tab[$];
    int             err_cnt  = 0;
    int             cyc_cnt  = 0;
    int             rx_stall = 0;
    bit             idle_en  = 1'b1;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- shadow model

    function automatic logic [15:0] ms_to_ticks(input logic [19:0] ms);
        int unsigned t;
        t = 32'(ms) / 32'(TICK_MS_P);
        return (t > 65535) ? 16'hFFFF : t[15:0];
    endfunction

    // The count is reported in four bits; clip it.
    function automatic int unsigned count_field();
        return (sh_count > 15) ? 15 : sh_count;
    endfunction

    function automatic void post_evt(input logic [2:0] kind, input int unsigned slot);
        ctst_pkg::t_evt e;
        e.event_kind = kind;
        e.task_slot  = slot[3:0];
        e.tick_count = sh_ticks;
        e.last       = 1'b0;
        evt_expect_q.push_back(e);
    endfunction

    // Remove one entry and pack the later ones down.
    function automatic void drop_slot(input int unsigned s);
        if (s >= sh_count)
            return;
        for (int unsigned j = s; j + 1 < sh_count; j++) begin
            sh_delay[j]  = sh_delay[j + 1];
            sh_period[j] = sh_period[j + 1];
            sh_pend[j]   = sh_pend[j + 1];
            sh_mark[j]   = sh_mark[j + 1];
        end
        sh_count--;
        sh_delay[sh_count]  = '0;
        sh_period[sh_count] = '0;
        sh_pend[sh_count]   = '0;
        sh_mark[sh_count]   = 1'b0;
    endfunction

    function automatic void clear_table();
        for (int k = 0; k < NUM_TASKS; k++) begin
            sh_delay[k]  = '0;
            sh_period[k] = '0;
            sh_pend[k]   = '0;
            sh_mark[k]   = 1'b0;
        end
        sh_count = 0;
    endfunction

    // Apply one request to the shadow table and queue the events it causes.
    function automatic void predict_sched(input ctst_pkg::t_req r);
        int unsigned    i;
        int unsigned    walk;
        int             n0;
        ctst_pkg::t_evt e;
        n0   = evt_expect_q.size();
        walk = 0;
        case (r.req_type)
            ctst_pkg::REQ_ADD: begin
                if (sh_count < NUM_TASKS) begin
                    sh_delay[sh_count]  = ms_to_ticks(r.delay_ms);
                    sh_period[sh_count] = ms_to_ticks(r.period_ms);
                    sh_pend[sh_count]   = '0;
                    sh_mark[sh_count]   = 1'b0;
                    sh_count++;
                    post_evt(ctst_pkg::EVT_ADDED, sh_count - 1);
                end else begin
                    post_evt(ctst_pkg::EVT_FULL, 0);
                end
            end
            ctst_pkg::REQ_TICK: begin
                sh_ticks = sh_ticks + 32'd1;
                for (i = 0; i < sh_count; i++) begin
                    if (sh_delay[i] != 0) begin
                        sh_delay[i] = sh_delay[i] - 16'd1;
                    end else begin
                        if (sh_pend[i] != 8'hFF)
                            sh_pend[i] = sh_pend[i] + 8'd1;
                        if (sh_period[i] != 0)
                            sh_delay[i] = sh_period[i];
                        else
                            sh_mark[i] = 1'b1;
                    end
                end
                post_evt(ctst_pkg::EVT_TICK_DONE, count_field());
            end
            ctst_pkg::REQ_DISPATCH: begin
                i = 0;
                while (i < sh_count) begin
                    if (sh_pend[i] != 0) begin
                        sh_pend[i] = sh_pend[i] - 8'd1;
                        if (walk < ctst_pkg::WALK_LIMIT) begin
                            post_evt(ctst_pkg::EVT_RUN, i);
                            walk++;
                        end
                    end
                    if (sh_mark[i]) begin
                        if (walk < ctst_pkg::WALK_LIMIT) begin
                            post_evt(ctst_pkg::EVT_REMOVED, i);
                            walk++;
                        end
                        drop_slot(i);
                    end else begin
                        i++;
                    end
                end
                post_evt(ctst_pkg::EVT_DISP_DONE, count_field());
            end
            ctst_pkg::REQ_DELETE: begin
                if (32'(r.slot_index) < sh_count) begin
                    drop_slot(32'(r.slot_index));
                    post_evt(ctst_pkg::EVT_REMOVED, 32'(r.slot_index));
                end else begin
                    post_evt(ctst_pkg::EVT_NOT_FOUND, 32'(r.slot_index));
                end
            end
            ctst_pkg::REQ_CLEAR: begin
                clear_table();
                post_evt(ctst_pkg::EVT_CLEARED, 0);
            end
            default: begin
            end
        endcase
        if (evt_expect_q.size() > n0) begin
            e      = evt_expect_q.pop_back();
            e.last = 1'b1;
            evt_expect_q.push_back(e);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void add_row(input logic [2:0] rq, input logic [19:0] dly,
                                    input logic [19:0] per, input logic [3:0] slot,
                                    input int reps, input bit fixed,
                                    input logic [2:0] kind, input logic [3:0] eslot);
        t_sched_row row;
        row.req.req_type   = rq;
        row.req.delay_ms   = dly;
        row.req.period_ms  = per;
        row.req.slot_index = slot;
        row.reps           = reps;
        row.fixed          = fixed;
        row.kind           = kind;
        row.slot           = eslot;
        dir_tab.push_back(row);
    endfunction

    // Random request: mostly adds, ticks and dispatches with small timing so that
    // tasks actually fire; a few wide values, deletes, clears and undefined codes.
    function automatic ctst_pkg::t_req pick_req();
        ctst_pkg::t_req r;
        int             sel;
        r.req_type   = ctst_pkg::REQ_TICK;
        r.delay_ms   = 20'($urandom);
        r.period_ms  = 20'($urandom);
        r.slot_index = 4'($urandom);
        sel          = $urandom_range(0, 99);
        if (sel < 4) begin
            r.req_type = 3'($urandom_range(5, 7));
        end else if (sel < 30) begin
            r.req_type = ctst_pkg::REQ_ADD;
            if ($urandom_range(0, 5) != 0) begin
                r.delay_ms  = 20'($urandom_range(0, 60));
                r.period_ms = ($urandom_range(0, 2) == 0) ? 20'($urandom_range(0, 9))
                                                          : 20'($urandom_range(10, 40));
            end
        end else if (sel < 70) begin
            r.req_type = ctst_pkg::REQ_TICK;
        end else if (sel < 85) begin
            r.req_type = ctst_pkg::REQ_DISPATCH;
        end else if (sel < 96) begin
            r.req_type = ctst_pkg::REQ_DELETE;
            if (sh_count > 0 && $urandom_range(0, 1) == 0)
                r.slot_index = 4'($urandom_range(0, sh_count - 1));
        end else begin
            r.req_type = ctst_pkg::REQ_CLEAR;
        end
        return r;
    endfunction

    // Drive one request transaction and hold it until accepted, then predict.
    // Valid stays high into the next request unless an idle burst follows.
    task automatic send_req(input t_sched_row row);
        ctst_pkg::t_evt e;
        int             n0;
        i_req       <= row.req;
        i_req_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_req_ready)
            @(posedge i_clk);
        n0 = evt_expect_q.size();
        predict_sched(row.req);
        if (row.fixed) begin
            // swap the predicted event for the hand-written one
            while (evt_expect_q.size() > n0)
                void'(evt_expect_q.pop_back());
            e.event_kind = row.kind;
            e.task_slot  = row.slot;
            e.tick_count = sh_ticks;
            e.last       = 1'b1;
            evt_expect_q.push_back(e);
        end
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the event channel in random bursts.
    always @(posedge i_clk) begin
        if (rx_stall != 0) begin
            rx_stall    <= rx_stall - 1;
            i_evt_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_stall    <= $urandom_range(0, 11);
            i_evt_ready <= 1'b0;
        end else begin
            i_evt_ready <= 1'b1;
        end
    end

    // Compare each accepted event transaction with the oldest expectation.
    always @(posedge i_clk) begin
        ctst_pkg::t_evt e;
        if (i_rst_n && o_evt_valid && i_evt_ready) begin
            if (evt_expect_q.size() == 0) begin
                $error("unexpected event: kind %0d slot %0d ticks %0d",
                       o_evt.event_kind, o_evt.task_slot, o_evt.tick_count);
                err_cnt++;
            end else begin
                e = evt_expect_q.pop_front();
                if (o_evt.event_kind !== e.event_kind) begin
                    $error("event_kind: expected %0d, got %0d", e.event_kind, o_evt.event_kind);
                    err_cnt++;
                end
                if (o_evt.task_slot !== e.task_slot) begin
                    $error("task_slot: expected %0d, got %0d", e.task_slot, o_evt.task_slot);
                    err_cnt++;
                end
                if (o_evt.tick_count !== e.tick_count) begin
                    $error("tick_count: expected %0d, got %0d", e.tick_count, o_evt.tick_count);
                    err_cnt++;
                end
                if (o_evt.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_evt.last);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: abort a hung run.
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        t_sched_row row;
        int         n_items;
        clear_table();
        sh_ticks = '0;

        // empty table: tick, dispatch, delete and undefined codes
        add_row(ctst_pkg::REQ_TICK,     0, 0, 0,  1, 1'b1, ctst_pkg::EVT_TICK_DONE, 0);
        add_row(ctst_pkg::REQ_DISPATCH, 0, 0, 0,  1, 1'b1, ctst_pkg::EVT_DISP_DONE, 0);
        add_row(ctst_pkg::REQ_DELETE,   0, 0, 15, 1, 1'b1, ctst_pkg::EVT_NOT_FOUND, 15);
        add_row(3'd5, 20'hFFFFF, 20'hFFFFF, 15, 1, 1'b0, ctst_pkg::EVT_ADDED, 0);
        add_row(3'd7, 0, 0, 0, 1, 1'b0, ctst_pkg::EVT_ADDED, 0);
        // fill the table: immediate one-shot, saturated timing, periodic, delayed one-shot
        add_row(ctst_pkg::REQ_ADD, 0,         0,         0, 1, 1'b1, ctst_pkg::EVT_ADDED, 0);
        add_row(ctst_pkg::REQ_ADD, 20'hFFFFF, 20'hFFFFF, 0, 1, 1'b1, ctst_pkg::EVT_ADDED, 1);
        add_row(ctst_pkg::REQ_ADD, 9,         10,        0, 1, 1'b1, ctst_pkg::EVT_ADDED, 2);
        add_row(ctst_pkg::REQ_ADD, 25,        9,         0, 1, 1'b1, ctst_pkg::EVT_ADDED, 3);
        add_row(ctst_pkg::REQ_ADD, 655359,    655359,    0, 1, 1'b1, ctst_pkg::EVT_ADDED, 4);
        add_row(ctst_pkg::REQ_ADD, 30,        40,        0, 1, 1'b1, ctst_pkg::EVT_ADDED, 5);
        add_row(ctst_pkg::REQ_ADD, 0,         5,         0, 1, 1'b1, ctst_pkg::EVT_ADDED, 6);
        add_row(ctst_pkg::REQ_ADD, 100,       20,        0, 1, 1'b1, ctst_pkg::EVT_ADDED, 7);
        add_row(ctst_pkg::REQ_ADD, 10,        10,        9, 1, 1'b1, ctst_pkg::EVT_FULL,  0);
        // one-shots pile up several runs before the dispatch removes them
        add_row(ctst_pkg::REQ_TICK,     0, 0, 0, 3, 1'b0, ctst_pkg::EVT_ADDED, 0);
        add_row(ctst_pkg::REQ_DISPATCH, 0, 0, 0, 1, 1'b0, ctst_pkg::EVT_ADDED, 0);
        add_row(ctst_pkg::REQ_DELETE,   0, 0, 0, 1, 1'b1, ctst_pkg::EVT_REMOVED, 0);
        add_row(ctst_pkg::REQ_DELETE,   0, 0, 6, 1, 1'b0, ctst_pkg::EVT_ADDED, 0);
        // tick run: let pending runs pile up on the periodic tasks
        add_row(ctst_pkg::REQ_TICK,     0, 0, 0, 20, 1'b0, ctst_pkg::EVT_ADDED, 0);
        add_row(ctst_pkg::REQ_DISPATCH, 0, 0, 0, 1,  1'b0, ctst_pkg::EVT_ADDED, 0);
        add_row(ctst_pkg::REQ_CLEAR,    0, 0, 0, 1,  1'b1, ctst_pkg::EVT_CLEARED, 0);
        add_row(ctst_pkg::REQ_DISPATCH, 0, 0, 0, 1,  1'b1, ctst_pkg::EVT_DISP_DONE, 0);
        add_row(ctst_pkg::REQ_DELETE,   0, 0, 0, 1,  1'b1, ctst_pkg::EVT_NOT_FOUND, 0);
        add_row(3'd6, 20'h5A5A5, 20'hA5A5A, 10, 1, 1'b0, ctst_pkg::EVT_ADDED, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            repeat (dir_tab[k].reps)
                send_req(dir_tab[k]);
        end

        // random mix; undefined codes do not count, the last fifth runs without idling
        row.reps  = 1;
        row.fixed = 1'b0;
        row.kind  = ctst_pkg::EVT_ADDED;
        row.slot  = '0;
        n_items   = 0;
        while (n_items < RAND_ITEMS) begin
            idle_en = (n_items < RAND_ITEMS * 4 / 5) && ((n_items % 40) < 30);
            row.req = pick_req();
            send_req(row);
            if (row.req.req_type <= ctst_pkg::REQ_CLEAR)
                n_items++;
        end
        i_req_valid <= 1'b0;

        // drain outstanding events, then let the core settle
        while (evt_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
